// ===== rtl/wsm_pkg.sv =====
`timescale 1ns / 1ps

package wsm_pkg;

    // Field widths of the sample, result and configuration words.
    localparam int DELTA_W   = 16;
    localparam int DUTY_W    = 8;
    localparam int ERR_W     = 17;
    localparam int TRIM_W    = 8;
    localparam int DB_W      = 15;
    localparam int DIVR_W    = 16;
    localparam int TLIM_W    = 7;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 16;

    // Divider operand widths: magnitudes of 17 bit signed values.
    localparam int MAG_W = ERR_W;
    localparam int CNT_W = $clog2(MAG_W + 1);

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_DEADBAND  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PROP_DIV  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_INT_DIV   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_INT_LIMIT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_TRIM_LIM  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_FLOOR     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_CEILING   = 3'd6;

    // Request into the shared divider.
    typedef struct packed {
        logic              start;
        logic [MAG_W-1:0]  dividend;
        logic [DIVR_W-1:0] divisor;
    } div_req_t;

    // Status out of the shared divider.
    typedef struct packed {
        logic             busy;
        logic             done;
        logic [MAG_W-1:0] quotient;
    } div_sts_t;

    // Magnitude of a signed value as an unsigned word of the same width.
    function automatic logic [MAG_W-1:0] mag_of(input logic [MAG_W-1:0] v);
        logic [MAG_W-1:0] r;
        r = v[MAG_W-1] ? (~v + MAG_W'(1)) : v;
        return r;
    endfunction

    // Gives a quotient magnitude its sign back.
    function automatic logic [MAG_W-1:0] with_sign(input logic [MAG_W-1:0] q,
                                                  input logic neg);
        logic [MAG_W-1:0] r;
        r = neg ? (~q + MAG_W'(1)) : q;
        return r;
    endfunction

endpackage

// ===== rtl/wsm_ifs.sv =====
`timescale 1ns / 1ps

interface wsm_sample_if;
    import wsm_pkg::*;
    logic                      valid;
    logic                      ready;
    logic signed [DELTA_W-1:0] left_delta;
    logic signed [DELTA_W-1:0] right_delta;
    logic [DUTY_W-1:0]         requested_left;
    logic [DUTY_W-1:0]         requested_right;

    modport source (output valid, left_delta, right_delta, requested_left,
                    requested_right, input ready);
    modport sink (input valid, left_delta, right_delta, requested_left,
                  requested_right, output ready);
endinterface

interface wsm_result_if;
    import wsm_pkg::*;
    logic                     valid;
    logic                     ready;
    logic signed [ERR_W-1:0]  speed_error;
    logic signed [TRIM_W-1:0] duty_trim;
    logic [DUTY_W-1:0]        left_duty;
    logic [DUTY_W-1:0]        right_duty;

    modport source (output valid, speed_error, duty_trim, left_duty, right_duty,
                    input ready);
    modport sink (input valid, speed_error, duty_trim, left_duty, right_duty,
                  output ready);
endinterface

interface wsm_cfg_if;
    import wsm_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_DAT_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/wsm_div.sv =====
`timescale 1ns / 1ps

// Restoring divider on unsigned magnitudes, one quotient bit per cycle.
module wsm_div (
    input  logic              clk,
    input  logic              rst_n,
    input  wsm_pkg::div_req_t req,
    output wsm_pkg::div_sts_t sts
);
    import wsm_pkg::*;

    logic [MAG_W-1:0]  quo_reg;
    logic [DIVR_W-1:0] rem_reg;
    logic [DIVR_W-1:0] div_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              busy_reg;
    logic              done_reg;

    logic [DIVR_W:0]   shifted;
    logic [DIVR_W:0]   diff;
    logic              fits;
    logic [DIVR_W-1:0] rem_next;

    // The remainder stays below the divisor, so the shifted value fits 17 bits.
    assign shifted  = {rem_reg, quo_reg[MAG_W-1]};
    assign fits     = shifted >= {1'b0, div_reg};
    assign diff     = shifted - {1'b0, div_reg};
    assign rem_next = fits ? diff[DIVR_W-1:0] : shifted[DIVR_W-1:0];

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            quo_reg  <= '0;
            rem_reg  <= '0;
            div_reg  <= '0;
        end
        else if (req.start)
        begin
            quo_reg  <= req.dividend;
            rem_reg  <= '0;
            div_reg  <= req.divisor;
            cnt_reg  <= CNT_W'(MAG_W);
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[MAG_W-2:0], fits};
            rem_reg <= rem_next;
            cnt_reg <= cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    assign sts.busy     = busy_reg;
    assign sts.done     = done_reg;
    assign sts.quotient = quo_reg;

endmodule

// ===== rtl/wheel_speed_matching_pi_trim_unit.sv =====
`timescale 1ns / 1ps

// Channel | Dir | Word
// --------+-----+---------------------------------------------------------------
// sample  | in  | left_delta, right_delta, requested_left, requested_right
// result  | out | speed_error, duty_trim, left_duty, right_duty
// cfg     | in  | index, data (register write, always ready)
//
// A sample word is taken only while the sequencer is idle, so a new word waits
// until the last one is through; the sequencer returns to idle at the edge that
// registers the result word. The proportional term and then the integral term
// each take a pass through the shared radix-2 divider.
// Reset clears the sequencer, the leaky integral, the trim and the registers to
// their defaults. A result word that is not taken holds the sequencer in its
// last step; the next sample word is still taken while the result waits.

module wheel_speed_matching_pi_trim_unit (
    input  logic  clk,
    input  logic  rst_n,
    wsm_sample_if.sink   sample,
    wsm_result_if.source result,
    wsm_cfg_if.sink      cfg
);
    import wsm_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ERR,
        S_LEAK,
        S_INT,
        S_DIVP,
        S_DIVI,
        S_TRIM,
        S_DUTY
    } state_t;

    state_t state_reg;

    // Configuration registers.
    logic [DB_W-1:0]   db_reg;
    logic [DIVR_W-1:0] pdiv_reg;
    logic [DIVR_W-1:0] idiv_reg;
    logic [DIVR_W-1:0] ilim_reg;
    logic [TLIM_W-1:0] tlim_reg;
    logic [DUTY_W-1:0] floor_reg;
    logic [DUTY_W-1:0] ceil_reg;

    // Latched sample word.
    logic [DELTA_W-1:0] left_reg;
    logic [DELTA_W-1:0] right_reg;
    logic [DUTY_W-1:0]  req_l_reg;
    logic [DUTY_W-1:0]  req_r_reg;

    // Working values and controller state.
    logic [ERR_W-1:0]  err_reg;
    logic [ERR_W-1:0]  scaled_reg;
    logic [ERR_W-1:0]  leaky_reg;
    logic [MAG_W-1:0]  qp_reg;
    logic [MAG_W-1:0]  qi_reg;
    logic [TRIM_W-1:0] trim_reg;

    // Result word registers.
    logic              out_valid_reg;
    logic [ERR_W-1:0]  out_err_reg;
    logic [TRIM_W-1:0] out_trim_reg;
    logic [DUTY_W-1:0] out_left_reg;
    logic [DUTY_W-1:0] out_right_reg;

    div_req_t div_req;
    div_sts_t div_sts;

    wsm_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .sts   (div_sts)
    );

    logic sample_acc;
    logic cfg_acc;
    logic out_free;
    logic out_load;

    assign sample.ready = (state_reg == S_IDLE);
    assign cfg.ready    = 1'b1;
    assign sample_acc   = sample.valid && sample.ready;
    assign cfg_acc      = cfg.valid && cfg.ready;
    assign out_free     = !out_valid_reg || result.ready;
    assign out_load     = (state_reg == S_DUTY) && out_free;

    // Speed error with the deadband applied.
    logic signed [ERR_W-1:0] diff_s;
    logic signed [ERR_W-1:0] db_s;
    logic [ERR_W-1:0]        err_next;

    assign diff_s   = $signed({left_reg[DELTA_W-1], left_reg})
                    - $signed({right_reg[DELTA_W-1], right_reg});
    assign db_s     = $signed({2'b00, db_reg});
    assign err_next = ((diff_s >= -db_s) && (diff_s <= db_s)) ? '0 : diff_s;

    // Leak: integral*7/8 with truncation toward zero, via 8x - x and a bias of 7
    // on negative values before the arithmetic shift.
    logic signed [ERR_W+2:0] leak_ext;
    logic signed [ERR_W+2:0] leak_x7;
    logic signed [ERR_W+2:0] leak_biased;
    logic [ERR_W-1:0]        scaled_next;

    assign leak_ext    = $signed({{3{leaky_reg[ERR_W-1]}}, leaky_reg});
    assign leak_x7     = (leak_ext <<< 3) - leak_ext;
    assign leak_biased = leak_x7[ERR_W+2] ? (leak_x7 + (ERR_W+3)'(7)) : leak_x7;
    assign scaled_next = leak_biased[ERR_W+2:3];

    // New integral, clamped to the symmetric limit.
    logic signed [ERR_W:0] int_sum;
    logic signed [ERR_W:0] ilim_s;
    logic signed [ERR_W:0] int_clamped;

    assign int_sum = $signed({scaled_reg[ERR_W-1], scaled_reg})
                   + $signed({err_reg[ERR_W-1], err_reg});
    assign ilim_s  = $signed({2'b00, ilim_reg});

    always_comb
    begin
        if (int_sum < -ilim_s)
        begin
            int_clamped = -ilim_s;
        end
        else if (int_sum > ilim_s)
        begin
            int_clamped = ilim_s;
        end
        else
        begin
            int_clamped = int_sum;
        end
    end

    // Trim: sum of the two quotients, clamped to the trim limit.
    logic signed [MAG_W:0] corr;
    logic signed [MAG_W:0] tlim_s;
    logic signed [MAG_W:0] trim_clamped;

    assign corr   = $signed({qp_reg[MAG_W-1], qp_reg}) + $signed({qi_reg[MAG_W-1], qi_reg});
    assign tlim_s = $signed({{(MAG_W+1-TLIM_W){1'b0}}, tlim_reg});

    always_comb
    begin
        if (corr < -tlim_s)
        begin
            trim_clamped = -tlim_s;
        end
        else if (corr > tlim_s)
        begin
            trim_clamped = tlim_s;
        end
        else
        begin
            trim_clamped = corr;
        end
    end

    // Duties. The floor is tested before the ceiling.
    localparam int DW = DUTY_W + 2;

    logic signed [DW-1:0] trim_w;
    logic signed [DW-1:0] floor_w;
    logic signed [DW-1:0] ceil_w;
    logic signed [DW-1:0] dl_raw;
    logic signed [DW-1:0] dr_raw;
    logic [DUTY_W-1:0]    dl_next;
    logic [DUTY_W-1:0]    dr_next;

    assign trim_w  = $signed({{(DW-TRIM_W){trim_reg[TRIM_W-1]}}, trim_reg});
    assign floor_w = $signed({2'b00, floor_reg});
    assign ceil_w  = $signed({2'b00, ceil_reg});
    assign dl_raw  = $signed({2'b00, req_l_reg}) - trim_w;
    assign dr_raw  = $signed({2'b00, req_r_reg}) + trim_w;

    always_comb
    begin
        if (dl_raw < floor_w)
        begin
            dl_next = floor_reg;
        end
        else if (dl_raw > ceil_w)
        begin
            dl_next = ceil_reg;
        end
        else
        begin
            dl_next = dl_raw[DUTY_W-1:0];
        end

        if (dr_raw < floor_w)
        begin
            dr_next = floor_reg;
        end
        else if (dr_raw > ceil_w)
        begin
            dr_next = ceil_reg;
        end
        else
        begin
            dr_next = dr_raw[DUTY_W-1:0];
        end
    end

    // The proportional division starts as the integral is written; the integral
    // division starts in the cycle the first quotient comes back.
    always_comb
    begin
        div_req.start    = (state_reg == S_INT) || ((state_reg == S_DIVP) && div_sts.done);
        div_req.dividend = (state_reg == S_INT) ? mag_of(err_reg) : mag_of(leaky_reg);
        div_req.divisor  = (state_reg == S_INT) ? pdiv_reg : idiv_reg;
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            db_reg        <= '0;
            pdiv_reg      <= DIVR_W'(1);
            idiv_reg      <= DIVR_W'(1);
            ilim_reg      <= DIVR_W'(1);
            tlim_reg      <= '0;
            floor_reg     <= '0;
            ceil_reg      <= '1;
            leaky_reg     <= '0;
            trim_reg      <= '0;
            out_valid_reg <= 1'b0;
            left_reg      <= '0;
            right_reg     <= '0;
            req_l_reg     <= '0;
            req_r_reg     <= '0;
            err_reg       <= '0;
            scaled_reg    <= '0;
            qp_reg        <= '0;
            qi_reg        <= '0;
            out_err_reg   <= '0;
            out_trim_reg  <= '0;
            out_left_reg  <= '0;
            out_right_reg <= '0;
        end
        else
        begin
            // A zero divisor or integral limit is stored as one.
            if (cfg_acc)
            begin
                case (cfg.index)
                    REG_DEADBAND:  db_reg    <= cfg.data[DB_W-1:0];
                    REG_PROP_DIV:  pdiv_reg  <= (cfg.data == '0) ? DIVR_W'(1) : cfg.data;
                    REG_INT_DIV:   idiv_reg  <= (cfg.data == '0) ? DIVR_W'(1) : cfg.data;
                    REG_INT_LIMIT: ilim_reg  <= (cfg.data == '0) ? DIVR_W'(1) : cfg.data;
                    REG_TRIM_LIM:  tlim_reg  <= cfg.data[TLIM_W-1:0];
                    REG_FLOOR:     floor_reg <= cfg.data[DUTY_W-1:0];
                    REG_CEILING:   ceil_reg  <= cfg.data[DUTY_W-1:0];
                    default:       ;
                endcase
            end

            // A new result word replaces one that is taken in the same cycle.
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (sample_acc)
                    begin
                        left_reg  <= sample.left_delta;
                        right_reg <= sample.right_delta;
                        req_l_reg <= sample.requested_left;
                        req_r_reg <= sample.requested_right;
                        state_reg <= S_ERR;
                    end
                end
                S_ERR:
                begin
                    err_reg   <= err_next;
                    state_reg <= S_LEAK;
                end
                S_LEAK:
                begin
                    scaled_reg <= scaled_next;
                    state_reg  <= S_INT;
                end
                S_INT:
                begin
                    leaky_reg <= int_clamped[ERR_W-1:0];
                    state_reg <= S_DIVP;
                end
                S_DIVP:
                begin
                    if (div_sts.done)
                    begin
                        qp_reg    <= with_sign(div_sts.quotient, err_reg[ERR_W-1]);
                        state_reg <= S_DIVI;
                    end
                end
                S_DIVI:
                begin
                    if (div_sts.done)
                    begin
                        qi_reg    <= with_sign(div_sts.quotient, leaky_reg[ERR_W-1]);
                        state_reg <= S_TRIM;
                    end
                end
                S_TRIM:
                begin
                    trim_reg  <= trim_clamped[TRIM_W-1:0];
                    state_reg <= S_DUTY;
                end
                S_DUTY:
                begin
                    if (out_free)
                    begin
                        out_err_reg   <= err_reg;
                        out_trim_reg  <= trim_reg;
                        out_left_reg  <= dl_next;
                        out_right_reg <= dr_next;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign result.valid       = out_valid_reg;
    assign result.speed_error = out_err_reg;
    assign result.duty_trim   = out_trim_reg;
    assign result.left_duty   = out_left_reg;
    assign result.right_duty  = out_right_reg;

    // Quotients only come back while the sequencer waits for them.
    a_div_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        div_sts.done |-> (state_reg == S_DIVP || state_reg == S_DIVI))
        else $error("divider finished outside a wait step");

    // The divider is never restarted while it is still working.
    a_div_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        div_req.start |-> !div_sts.busy)
        else $error("divider restarted while busy");

    // A result word only appears after the duty step.
    a_result_from_duty: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_DUTY))
        else $error("result word raised outside the duty step");

    // The trim never reaches the most negative 8 bit code.
    a_trim_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_trim_reg != {1'b1, {(TRIM_W-1){1'b0}}}))
        else $error("trim outside its symmetric range");

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps

// Testbench for the wheel speed matching trim unit. It predicts every result word
// from the sample words that the block accepts and compares each result with the
// oldest prediction. A set of named test tasks runs in turn. Each task streams
// sample words; a task that programs the registers does so first, while the
// block is idle. The receiver stalls at random in its own process, and the
// checker is a separate process as well.
module tb_top;
    import wsm_pkg::*;

    // Index 7 is not a register; a write to it must change nothing.
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

    // Words per random chunk; every chunk runs under its own register settings.
    localparam int CHUNK_WORDS = 64;

    // One result word as the block should produce it.
    typedef struct packed {
        logic signed [ERR_W-1:0]  speed_error;
        logic signed [TRIM_W-1:0] duty_trim;
        logic [DUTY_W-1:0]        left_duty;
        logic [DUTY_W-1:0]        right_duty;
    } trim_result_t;

    // Raw data words for the seven registers, written before the block masks
    // or fixes them.
    typedef struct {
        logic [CFG_DAT_W-1:0] deadband;
        logic [CFG_DAT_W-1:0] prop_div;
        logic [CFG_DAT_W-1:0] int_div;
        logic [CFG_DAT_W-1:0] int_lim;
        logic [CFG_DAT_W-1:0] trim_lim;
        logic [CFG_DAT_W-1:0] duty_floor;
        logic [CFG_DAT_W-1:0] duty_ceiling;
    } trim_settings_t;

    logic clk;
    logic rst_n;

    wsm_sample_if sample_ch();
    wsm_result_if result_ch();
    wsm_cfg_if    cfg_ch();

    wheel_speed_matching_pi_trim_unit u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .sample (sample_ch),
        .result (result_ch),
        .cfg    (cfg_ch)
    );

    // The controller as the testbench sees it: registers after masking and
    // the integral that carries over from one sample to the next.
    logic [DB_W-1:0]          deadband_q;
    logic [DIVR_W-1:0]        prop_div_q;
    logic [DIVR_W-1:0]        int_div_q;
    logic [DIVR_W-1:0]        int_lim_q;
    logic [TLIM_W-1:0]        trim_lim_q;
    logic [DUTY_W-1:0]        floor_q;
    logic [DUTY_W-1:0]        ceiling_q;
    logic signed [ERR_W-1:0]  integral_q;

    // Result words predicted but not yet seen, oldest first.
    trim_result_t pending_trims[$];
    trim_result_t want;
    int           mismatch_count;

    // Idle rates in percent, and the length of a forced receiver stall.
    int send_idle_pct;
    int recv_idle_pct;
    int hold_len;

    always #10 clk = ~clk;

    // A generous bound. A clean run takes a few milliseconds of simulated time.
    initial
    begin
        #40_000_000;
        $display("status: fail");
        $finish;
    end

    // The lower bound is tested first, so a floor above the ceiling wins.
    function automatic int clamp_int(input int v, input int lo, input int hi);
        if (v < lo)
        begin
            return lo;
        end
        if (v > hi)
        begin
            return hi;
        end
        return v;
    endfunction

    // Advances the controller state by one sample word and returns the result
    // word that it causes. SystemVerilog integer division truncates toward zero,
    // as the block does.
    function automatic trim_result_t predict_trim(input logic signed [DELTA_W-1:0] l_d,
                                                  input logic signed [DELTA_W-1:0] r_d,
                                                  input logic [DUTY_W-1:0] req_l,
                                                  input logic [DUTY_W-1:0] req_r);
        int           err;
        int           db;
        int           lim;
        int           tl;
        int           sum;
        int           corr;
        int           trim;
        trim_result_t res;
        err = int'(l_d) - int'(r_d);
        db  = int'(deadband_q);
        lim = int'(int_lim_q);
        tl  = int'(trim_lim_q);
        if (err >= -db && err <= db)
        begin
            err = 0;
        end
        // The integral leaks by one eighth on every sample.
        sum = clamp_int((int'(integral_q) * 7) / 8 + err, -lim, lim);
        integral_q = ERR_W'(sum);
        corr = err / int'(prop_div_q) + sum / int'(int_div_q);
        trim = clamp_int(corr, -tl, tl);
        res.speed_error = ERR_W'(err);
        res.duty_trim   = TRIM_W'(trim);
        res.left_duty   = DUTY_W'(clamp_int(int'(req_l) - trim, int'(floor_q),
                                            int'(ceiling_q)));
        res.right_duty  = DUTY_W'(clamp_int(int'(req_r) + trim, int'(floor_q),
                                            int'(ceiling_q)));
        return res;
    endfunction

    // Writes one register and mirrors the write into the predictor. Valid stays
    // high, so that back-to-back writes never lower and raise it in one step.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DAT_W-1:0] val);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        @(posedge clk);
        while (!cfg_ch.ready)
        begin
            @(posedge clk);
        end
        case (idx)
            REG_DEADBAND:  deadband_q = val[DB_W-1:0];
            REG_PROP_DIV:  prop_div_q = (val == '0) ? DIVR_W'(1) : val;
            REG_INT_DIV:   int_div_q  = (val == '0) ? DIVR_W'(1) : val;
            REG_INT_LIMIT: int_lim_q  = (val == '0) ? DIVR_W'(1) : val;
            REG_TRIM_LIM:  trim_lim_q = val[TLIM_W-1:0];
            REG_FLOOR:     floor_q    = val[DUTY_W-1:0];
            REG_CEILING:   ceiling_q  = val[DUTY_W-1:0];
            default:       ;
        endcase
    endtask

    // Programs all seven registers, then the unused index with junk.
    task automatic apply_settings(input trim_settings_t s);
        write_reg(REG_DEADBAND, s.deadband);
        write_reg(REG_PROP_DIV, s.prop_div);
        write_reg(REG_INT_DIV, s.int_div);
        write_reg(REG_INT_LIMIT, s.int_lim);
        write_reg(REG_TRIM_LIM, s.trim_lim);
        write_reg(REG_FLOOR, s.duty_floor);
        write_reg(REG_CEILING, s.duty_ceiling);
        write_reg(REG_UNUSED, CFG_DAT_W'($urandom));
        cfg_ch.valid <= 1'b0;
    endtask

    // Offers one sample word, idling first at the current rate, and records
    // its prediction once the block takes it. Valid is left high on return.
    task automatic send_sample(input logic signed [DELTA_W-1:0] l_d,
                               input logic signed [DELTA_W-1:0] r_d,
                               input logic [DUTY_W-1:0] req_l,
                               input logic [DUTY_W-1:0] req_r);
        while ($urandom_range(99) < send_idle_pct)
        begin
            sample_ch.valid <= 1'b0;
            @(posedge clk);
        end
        sample_ch.valid           <= 1'b1;
        sample_ch.left_delta      <= l_d;
        sample_ch.right_delta     <= r_d;
        sample_ch.requested_left  <= req_l;
        sample_ch.requested_right <= req_r;
        @(posedge clk);
        while (!sample_ch.ready)
        begin
            @(posedge clk);
        end
        pending_trims.push_back(predict_trim(l_d, r_d, req_l, req_r));
    endtask

    // Stops offering and waits until every predicted word has come back. The
    // extra cycles cover the step in which the sequencer returns to idle.
    task automatic wait_drained();
        sample_ch.valid <= 1'b0;
        while (pending_trims.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (4) @(posedge clk);
    endtask

    // The register defaults hold the trim at zero, so the duties pass straight
    // through. The largest errors of both signs go through as well.
    task automatic test_reset_defaults();
        send_sample(16'sh7FFF, 16'sh8000, 8'd0, 8'd255);
        send_sample(16'sh8000, 16'sh7FFF, 8'd255, 8'd0);
        send_sample(16'sd0, 16'sd0, 8'd128, 8'd128);
        send_sample(-16'sd1, 16'sd0, 8'd1, 8'd254);
        wait_drained();
    endtask

    // Errors on the deadband edge are zeroed, and one count past it is not. The
    // second setting writes all ones, so the top bit must be dropped.
    task automatic test_deadband_edges();
        apply_settings('{16'd500, 16'd4, 16'd2, 16'd1000, 16'd40, 16'd0, 16'd255});
        send_sample(16'sd1000, 16'sd500, 8'd100, 8'd100);
        send_sample(16'sd500, 16'sd1000, 8'd100, 8'd100);
        send_sample(16'sd1001, 16'sd500, 8'd100, 8'd100);
        send_sample(16'sd500, 16'sd1001, 8'd100, 8'd100);
        wait_drained();
        apply_settings('{16'hFFFF, 16'd4, 16'd2, 16'd1000, 16'd40, 16'd0, 16'd255});
        send_sample(16'sh7FFF, 16'sd0, 8'd60, 8'd60);
        send_sample(16'sh7FFF, -16'sd1, 8'd60, 8'd60);
        wait_drained();
    endtask

    // Zero divisors and a zero integral limit must behave as one.
    task automatic test_zero_writes();
        apply_settings('{16'd0, 16'd0, 16'd0, 16'd0, 16'd127, 16'd0, 16'd255});
        send_sample(16'sd100, 16'sd0, 8'd50, 8'd200);
        send_sample(16'sd0, 16'sd100, 8'd50, 8'd200);
        send_sample(16'sh7FFF, 16'sh8000, 8'd128, 8'd128);
        send_sample(16'sh8000, 16'sh7FFF, 8'd128, 8'd128);
        wait_drained();
    endtask

    // Full trims push the duties into the bounds, once with the floor above the
    // ceiling and once with an ordinary window.
    task automatic test_duty_bounds();
        apply_settings('{16'd0, 16'd1, 16'd1, 16'hFFFF, 16'd127, 16'd200, 16'd50});
        send_sample(16'sd1000, 16'sd0, 8'd255, 8'd0);
        send_sample(16'sd0, 16'sd0, 8'd100, 8'd100);
        send_sample(16'sd0, 16'sd1000, 8'd0, 8'd255);
        wait_drained();
        apply_settings('{16'd0, 16'd1, 16'd1, 16'hFFFF, 16'd127, 16'd20, 16'd230});
        send_sample(16'sd1000, 16'sd0, 8'd255, 8'd0);
        send_sample(16'sd0, 16'sd0, 8'd100, 8'd100);
        send_sample(16'sd0, 16'sd1000, 8'd0, 8'd255);
        wait_drained();
    endtask

    // The receiver refuses everything for a long stretch while the sender
    // keeps offering. The block takes one more word and must then stall its
    // input until the result drains.
    task automatic test_result_backpressure();
        int saved_pct;
        saved_pct = send_idle_pct;
        send_idle_pct = 0;
        @(negedge clk);
        hold_len = 400;
        @(posedge clk);
        for (int i = 0; i < 24; i++)
        begin
            send_sample(DELTA_W'($urandom_range(600)), DELTA_W'($urandom_range(600)),
                        DUTY_W'($urandom), DUTY_W'($urandom));
        end
        wait_drained();
        send_idle_pct = saved_pct;
    endtask

    // Random traffic in chunks. Each chunk gets fresh settings and a steady bias
    // in the wheel difference, so that the integral builds up, saturates and
    // leaks. A share of the words carries fully random deltas.
    task automatic test_random_traffic(input int send_pct, input int recv_pct,
                                       input int n_chunks);
        trim_settings_t     s;
        logic signed [DELTA_W-1:0] l_d;
        logic signed [DELTA_W-1:0] r_d;
        logic [DUTY_W-1:0]  req_l;
        logic [DUTY_W-1:0]  req_r;
        int                 bias;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        for (int c = 0; c < n_chunks; c++)
        begin
            case (c % 10)
                0: s = '{16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0};
                1: s = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                         16'hFFFF};
                default:
                begin
                    s.deadband = CFG_DAT_W'(($urandom_range(3) == 0)
                                            ? $urandom_range(65535) : $urandom_range(64));
                    s.prop_div = CFG_DAT_W'(($urandom_range(3) == 0)
                                            ? $urandom_range(65535) : $urandom_range(32));
                    s.int_div  = CFG_DAT_W'(($urandom_range(3) == 0)
                                            ? $urandom_range(65535) : $urandom_range(64));
                    s.int_lim  = CFG_DAT_W'(($urandom_range(3) == 0)
                                            ? $urandom_range(65535) : $urandom_range(2000));
                    s.trim_lim = CFG_DAT_W'(($urandom_range(3) == 0)
                                            ? $urandom_range(65535) : $urandom_range(127));
                    s.duty_floor   = CFG_DAT_W'(($urandom_range(4) == 0)
                                                ? $urandom_range(65535)
                                                : $urandom_range(60));
                    s.duty_ceiling = CFG_DAT_W'(($urandom_range(4) == 0)
                                                ? $urandom_range(65535)
                                                : $urandom_range(255, 190));
                end
            endcase
            apply_settings(s);
            bias = int'($urandom_range(600)) - 300;
            for (int i = 0; i < CHUNK_WORDS; i++)
            begin
                if ($urandom_range(4) == 0)
                begin
                    l_d = DELTA_W'($urandom);
                    r_d = DELTA_W'($urandom);
                end
                else
                begin
                    l_d = DELTA_W'(int'($urandom_range(4000)) - 2000);
                    r_d = DELTA_W'(int'(l_d) - bias + int'($urandom_range(100)) - 50);
                end
                if ($urandom_range(7) == 0)
                begin
                    req_l = $urandom_range(1) ? 8'hFF : 8'h00;
                    req_r = $urandom_range(1) ? 8'hFF : 8'h00;
                end
                else
                begin
                    req_l = DUTY_W'($urandom);
                    req_r = DUTY_W'($urandom);
                end
                send_sample(l_d, r_d, req_l, req_r);
            end
            wait_drained();
        end
    endtask

    // The receiver's ready. A forced stall overrides the random idling.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_ch.ready <= 1'b0;
        end
        else if (hold_len > 0)
        begin
            result_ch.ready <= 1'b0;
            hold_len <= hold_len - 1;
        end
        else
        begin
            result_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Checks every accepted result word against the oldest prediction.
    always @(posedge clk)
    begin
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            if (pending_trims.size() == 0)
            begin
                $error("result word with no prediction waiting");
                mismatch_count++;
            end
            else
            begin
                want = pending_trims.pop_front();
                if (result_ch.speed_error !== want.speed_error)
                begin
                    $error("speed_error: expected %0d, actual %0d",
                           want.speed_error, result_ch.speed_error);
                    mismatch_count++;
                end
                if (result_ch.duty_trim !== want.duty_trim)
                begin
                    $error("duty_trim: expected %0d, actual %0d",
                           want.duty_trim, result_ch.duty_trim);
                    mismatch_count++;
                end
                if (result_ch.left_duty !== want.left_duty)
                begin
                    $error("left_duty: expected %0d, actual %0d",
                           want.left_duty, result_ch.left_duty);
                    mismatch_count++;
                end
                if (result_ch.right_duty !== want.right_duty)
                begin
                    $error("right_duty: expected %0d, actual %0d",
                           want.right_duty, result_ch.right_duty);
                    mismatch_count++;
                end
            end
        end
    end

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        hold_len = 0;
        mismatch_count = 0;
        sample_ch.valid           <= 1'b0;
        sample_ch.left_delta      <= '0;
        sample_ch.right_delta     <= '0;
        sample_ch.requested_left  <= '0;
        sample_ch.requested_right <= '0;
        cfg_ch.valid <= 1'b0;
        cfg_ch.index <= '0;
        cfg_ch.data  <= '0;

        // Register defaults and cleared state, as the block comes out of reset.
        deadband_q = '0;
        prop_div_q = DIVR_W'(1);
        int_div_q  = DIVR_W'(1);
        int_lim_q  = DIVR_W'(1);
        trim_lim_q = '0;
        floor_q    = '0;
        ceiling_q  = 8'd255;
        integral_q = '0;

        // The first stretch: the sender idles a little and the receiver a lot.
        send_idle_pct = 14;
        recv_idle_pct = 75;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_deadband_edges();
        test_zero_writes();
        test_duty_bounds();
        test_result_backpressure();
        test_random_traffic(14, 75, 10);
        test_random_traffic(75, 14, 10);
        test_random_traffic(0, 0, 10);

        // Any stray word still in flight would show up within one sample time.
        repeat (60) @(posedge clk);
        if (pending_trims.size() != 0)
        begin
            $error("%0d predicted result words never arrived", pending_trims.size());
            mismatch_count++;
        end
        if (mismatch_count == 0)
        begin
            $display("status: pass");
        end
        else
        begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
